// File: rtl/core/rar_pkg.sv
package rar_pkg;

    // stream widths
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 4;
    localparam int ID_W      = 32;
    localparam int KIND_W    = 3;
    localparam int MT_W      = 2;

    // defaults
    localparam int          WINDOW_DEF      = 16;
    localparam logic [31:0] TIMEOUT_DEF     = 32'd10000;

    // result kinds
    localparam logic [KIND_W-1:0] K_CSTART  = 3'd0;
    localparam logic [KIND_W-1:0] K_CDATA   = 3'd1;
    localparam logic [KIND_W-1:0] K_CEND    = 3'd2;
    localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd3;
    localparam logic [KIND_W-1:0] K_BEYOND  = 3'd4;

    // packet message types
    localparam logic [MT_W-1:0] MT_START = 2'd0;
    localparam logic [MT_W-1:0] MT_DATA  = 2'd1;
    localparam logic [MT_W-1:0] MT_END   = 2'd2;

endpackage

// File: rtl/core/reorder_ack_receiver_unit.sv
// selective-repeat receiver: turns packet and tick requests into confirmations
// slave channel: one request per event; s_tuser says whether it is a tick or a
//   packet (plus the format-check flag and message type), s_tdata carries the
//   header words and the payload handle
// master channel: one or more result requests per event, m_tlast on the final
//   one; events that cause nothing (ignored packets, quiet ticks) give nothing
// cfg_we/cfg_wdata write the idle-tick timeout; the user must write it only while
//   the block is idle; the block itself does not enforce this
// sequence: a request is taken in S_IDLE and evaluated in S_EVAL, where ignored
//   and result-less packets end; a tick passes S_TICK and S_TCMP (increment and
//   compare both use the shared 32-bit add/subtract unit); in-order data passes
//   S_ADV, then S_RD and S_ADV per released buffered successor, as each release
//   reads the slot memory's registered port and steps the expected id in the adder
// s_tready is high only while the sequencer is idle; a finished result waits in
//   the output register, so the next request is taken while it is pending
// a stalled master side holds the sequencer in any state that has a result to
//   present, with m_tdata/m_tuser/m_tlast held stable
// reset (aresetn low, synchronous) returns to waiting for a start packet,
//   clears all slot-full flags and the id counters; timeout reloads 10000
module reorder_ack_receiver_unit #(
    parameter int WINDOW = rar_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // conn_tag, seq_id, src_addr, payload_in
    input  logic [rar_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd, pkt_valid, msg_type[1:0]
    input  logic [rar_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ack_id, ack_conn, payload_out
    output logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[2:0], deliver
    output logic [rar_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W:0]   WIN_S   = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WINDOW);
    localparam logic [31:0]      WIN_ID  = 32'(WINDOW);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_TICK = 3'd2;
    localparam logic [2:0] S_TCMP = 3'd3;
    localparam logic [2:0] S_ADV  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;

    // transfer phases
    localparam logic [1:0] PH_WAIT_START = 2'd0;
    localparam logic [1:0] PH_WAIT_DATA  = 2'd1;
    localparam logic [1:0] PH_DONE       = 2'd2;
    localparam logic [1:0] PH_FAILED     = 2'd3;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [31:0]       peer_conn_reg, peer_conn_next;
    logic [31:0]       peer_addr_reg, peer_addr_next;
    logic [31:0]       ne_reg, ne_next;
    logic [IDX_W-1:0]  ne_slot_reg, ne_slot_next;
    logic [31:0]       idle_reg, idle_next;
    logic [31:0]       timeout_reg, timeout_next;
    logic [WINDOW-1:0] slot_full_reg, slot_full_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              from_mem_reg, from_mem_next;

    // latched request
    logic              cmd_reg, vld_reg;
    logic [1:0]        mt_reg;
    logic [31:0]       tag_reg, seq_reg, src_reg, pay_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        kind_reg, kind_next;
    logic [31:0]       ack_id_reg, ack_id_next;
    logic [31:0]       ack_conn_reg, ack_conn_next;
    logic              deliver_reg, deliver_next;
    logic [31:0]       payload_reg, payload_next;
    logic              last_reg, last_next;

    // slot memory
    logic [31:0]       slot_mem [WINDOW];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    // shared add/subtract unit
    logic [31:0]       alu_a, alu_b;
    logic              alu_sub;
    logic [32:0]       alu_sum;
    logic [31:0]       alu_res;
    logic              alu_carry, alu_zero;

    logic              out_free, in_acc, hdr_match, more;
    logic [IDX_W:0]    wsum;
    logic [IDX_W-1:0]  wslot, nxt_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // operand selection per sequencer step
    always_comb begin
        alu_a   = seq_reg;
        alu_b   = ne_reg;
        alu_sub = 1'b1;
        case (state_reg)
            S_TICK: begin
                alu_a   = idle_reg;
                alu_b   = 32'd1;
                alu_sub = 1'b0;
            end
            S_TCMP: begin
                alu_a   = idle_reg;
                alu_b   = timeout_reg;
                alu_sub = 1'b1;
            end
            S_ADV: begin
                alu_a   = ne_reg;
                alu_b   = 32'd1;
                alu_sub = 1'b0;
            end
            default: ;
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {32{alu_sub}}} + {32'd0, alu_sub};
    assign alu_res   = alu_sum[31:0];
    assign alu_carry = alu_sum[32];
    assign alu_zero  = (alu_res == 32'd0);

    assign hdr_match = (tag_reg == peer_conn_reg) && (src_reg == peer_addr_reg);

    // slot of an id ahead of the expected one: expected slot plus distance, wrapped
    assign wsum  = {1'b0, ne_slot_reg} + {1'b0, alu_res[IDX_W-1:0]};
    assign wslot = (wsum >= WIN_S) ? IDX_W'(wsum - WIN_S) : wsum[IDX_W-1:0];

    // slot of the id after the expected one; a wrap of the id restarts at slot 0
    assign nxt_slot = (alu_carry || ne_slot_reg == SLOT_MAX) ? '0
                                                            : ne_slot_reg + IDX_W'(1);

    assign more = slot_full_reg[nxt_slot] && ((cnt_reg + CNT_W'(1)) < WIN_C);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        peer_conn_next = peer_conn_reg;
        peer_addr_next = peer_addr_reg;
        ne_next        = ne_reg;
        ne_slot_next   = ne_slot_reg;
        idle_next      = idle_reg;
        timeout_next   = cfg_we ? cfg_wdata : timeout_reg;
        slot_full_next = slot_full_reg;
        cnt_next       = cnt_reg;
        from_mem_next  = from_mem_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        kind_next      = kind_reg;
        ack_id_next    = ack_id_reg;
        ack_conn_next  = ack_conn_reg;
        deliver_next   = deliver_reg;
        payload_next   = payload_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = wslot;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    // single-result defaults, loaded even when no result follows
                    ack_id_next   = seq_reg;
                    ack_conn_next = peer_conn_reg;
                    deliver_next  = 1'b0;
                    payload_next  = 32'd0;
                    last_next     = 1'b1;
                    if (phase_reg == PH_DONE || phase_reg == PH_FAILED) begin
                        state_next = S_IDLE;
                    end else if (cmd_reg) begin
                        state_next = S_TICK;
                    end else if (!vld_reg) begin
                        state_next = S_IDLE;
                    end else if (phase_reg == PH_WAIT_START) begin
                        if (mt_reg == rar_pkg::MT_START) begin
                            peer_conn_next = tag_reg;
                            peer_addr_next = src_reg;
                            idle_next      = 32'd0;
                            phase_next     = PH_WAIT_DATA;
                            m_valid_next   = 1'b1;
                            kind_next      = rar_pkg::K_CSTART;
                            ack_conn_next  = tag_reg;
                        end
                    end else if (hdr_match) begin
                        case (mt_reg)
                            rar_pkg::MT_START: begin
                                m_valid_next = 1'b1;
                                kind_next    = rar_pkg::K_CSTART;
                            end
                            rar_pkg::MT_DATA: begin
                                if (!alu_carry) begin
                                    // older id: confirm again
                                    m_valid_next = 1'b1;
                                    kind_next    = rar_pkg::K_CDATA;
                                end else if (alu_zero) begin
                                    state_next    = S_ADV;
                                    from_mem_next = 1'b0;
                                    cnt_next      = '0;
                                end else if (alu_res < WIN_ID) begin
                                    if (!slot_full_reg[wslot]) begin
                                        slot_full_next[wslot] = 1'b1;
                                        mem_we                = 1'b1;
                                        idle_next             = 32'd0;
                                    end
                                    m_valid_next = 1'b1;
                                    kind_next    = rar_pkg::K_CDATA;
                                end else begin
                                    m_valid_next = 1'b1;
                                    kind_next    = rar_pkg::K_BEYOND;
                                end
                            end
                            rar_pkg::MT_END: begin
                                if (alu_carry && alu_zero) begin
                                    idle_next    = 32'd0;
                                    phase_next   = PH_DONE;
                                    m_valid_next = 1'b1;
                                    kind_next    = rar_pkg::K_CEND;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            S_TICK: begin
                // saturating increment: carry out means it was already at max
                idle_next  = alu_carry ? idle_reg : alu_res;
                state_next = S_TCMP;
            end

            S_TCMP: begin
                if (alu_carry) begin
                    if (out_free) begin
                        phase_next    = PH_FAILED;
                        m_valid_next  = 1'b1;
                        kind_next     = rar_pkg::K_TIMEOUT;
                        ack_id_next   = 32'd0;
                        ack_conn_next = peer_conn_reg;
                        deliver_next  = 1'b0;
                        payload_next  = 32'd0;
                        last_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end

            S_ADV: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = rar_pkg::K_CDATA;
                    ack_id_next   = ne_reg;
                    ack_conn_next = peer_conn_reg;
                    deliver_next  = 1'b1;
                    payload_next  = from_mem_reg ? rd_data_reg : pay_reg;
                    last_next     = !more;
                    ne_next       = alu_res;
                    ne_slot_next  = nxt_slot;
                    idle_next     = 32'd0;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    from_mem_next = 1'b1;
                    if (from_mem_reg) begin
                        slot_full_next[ne_slot_reg] = 1'b0;
                    end
                    state_next = more ? S_RD : S_IDLE;
                end
            end

            S_RD: begin
                // memory read of the new expected slot lands in rd_data_reg
                state_next = S_ADV;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_WAIT_START;
            peer_conn_reg <= 32'd0;
            peer_addr_reg <= 32'd0;
            ne_reg        <= 32'd0;
            ne_slot_reg   <= '0;
            idle_reg      <= 32'd0;
            timeout_reg   <= rar_pkg::TIMEOUT_DEF;
            slot_full_reg <= '0;
            cnt_reg       <= '0;
            from_mem_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            peer_conn_reg <= peer_conn_next;
            peer_addr_reg <= peer_addr_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            idle_reg      <= idle_next;
            timeout_reg   <= timeout_next;
            slot_full_reg <= slot_full_next;
            cnt_reg       <= cnt_next;
            from_mem_reg  <= from_mem_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg <= s_tuser[0];
            vld_reg <= s_tuser[1];
            mt_reg  <= s_tuser[3:2];
            tag_reg <= s_tdata[31:0];
            seq_reg <= s_tdata[63:32];
            src_reg <= s_tdata[95:64];
            pay_reg <= s_tdata[127:96];
        end
        kind_reg     <= kind_next;
        ack_id_reg   <= ack_id_next;
        ack_conn_reg <= ack_conn_next;
        deliver_reg  <= deliver_next;
        payload_reg  <= payload_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= pay_reg;
        end
        rd_data_reg <= slot_mem[ne_slot_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {payload_reg, ack_conn_reg, ack_id_reg};
    assign m_tuser  = {deliver_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

// File: rtl/core/rar_checker.sv
module rar_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rar_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    // only data confirmations come in runs
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != rar_pkg::K_CDATA |-> m_tlast && !m_tuser[3])
        else $error("non-data result not final or delivering");

    // payload is zero unless delivered
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> m_tdata[95:64] == 32'd0)
        else $error("payload without delivery");

    // timeout carries id zero
    a_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == rar_pkg::K_TIMEOUT |-> m_tdata[31:0] == 32'd0)
        else $error("timeout with nonzero id");

endmodule

bind reorder_ack_receiver_unit rar_checker u_rar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          WIN         = rar_pkg::WINDOW_DEF;
    localparam int          DRAIN_WAIT  = 48;    // longest drain releases 15 buffered successors
    localparam int          STALL_LIMIT = 2000;  // cycles with no request moving
    localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
    localparam logic        CMD_PKT     = 1'b0;
    localparam logic        CMD_TICK    = 1'b1;
    localparam logic [1:0]  MT_OTHER    = 2'd3;

    typedef enum logic [1:0] {RX_IDLE, RX_OPEN, RX_DONE, RX_FAILED} rx_phase_t;

    // one input event as the sender sees it
    typedef struct packed {
        logic        cmd;
        logic        fmt_ok;
        logic [1:0]  mtype;
        logic [31:0] conn;
        logic [31:0] seq;
        logic [31:0] src;
        logic [31:0] pay;
    } pkt_t;

    // one confirmation, flag or failure result
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] conn;
        logic        dlv;
        logic [31:0] pay;
        logic        last;
    } ack_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [31:0]                    cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [rar_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [rar_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [rar_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [rar_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           m_tlast;

    reorder_ack_receiver_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting to be offered, results waiting to arrive
    pkt_t pkt_q[$];
    ack_t ack_q[$];

    // shadow of the receiver state
    rx_phase_t   rx_phase     = RX_IDLE;
    logic [31:0] timeout_lim  = rar_pkg::TIMEOUT_DEF;
    logic [31:0] peer_conn_q  = '0;
    logic [31:0] peer_addr_q  = '0;
    logic [31:0] next_id      = '0;
    logic [31:0] idle_ticks   = '0;
    logic        slot_full[WIN];
    logic [31:0] slot_pay[WIN];

    int  errs        = 0;
    int  quiet_cyc   = 0;
    int  live_cnt    = 0;
    bit  s_took      = 1'b0;
    bit  m_took      = 1'b0;
    bit  s_burst     = 1'b0;
    bit  m_burst     = 1'b0;
    int  s_gap       = 0;
    int  m_gap       = 0;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;

    initial begin
        for (int i = 0; i < WIN; i++) slot_full[i] = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void emit_ack(logic [2:0] kind, logic [31:0] id, logic dlv,
                                     logic [31:0] pay);
        ack_t a;
        a.kind = kind;
        a.id   = id;
        a.conn = peer_conn_q;
        a.dlv  = dlv;
        a.pay  = dlv ? pay : 32'd0;
        a.last = 1'b0;
        ack_q.push_back(a);
    endfunction

    // data packet from the latched peer: deliver, store, reconfirm or flag
    function automatic void take_data(logic [31:0] seq, logic [31:0] pay);
        logic [31:0] ahead;
        int          n;
        int          s;
        ahead = seq - next_id;
        if (seq < next_id) begin
            // older id, confirm again
            emit_ack(rar_pkg::K_CDATA, seq, 1'b0, '0);
        end else if (seq == next_id) begin
            // in order: deliver, then release buffered successors
            emit_ack(rar_pkg::K_CDATA, seq, 1'b1, pay);
            next_id    = next_id + 32'd1;
            idle_ticks = '0;
            n = 1;
            s = int'(next_id % WIN);
            while (slot_full[s] && n < WIN) begin
                slot_full[s] = 1'b0;
                emit_ack(rar_pkg::K_CDATA, next_id, 1'b1, slot_pay[s]);
                next_id = next_id + 32'd1;
                n++;
                s = int'(next_id % WIN);
            end
        end else if (ahead < WIN) begin
            // inside the window: first payload stored is kept
            s = int'(seq % WIN);
            if (!slot_full[s]) begin
                slot_full[s] = 1'b1;
                slot_pay[s]  = pay;
                idle_ticks   = '0;
            end
            emit_ack(rar_pkg::K_CDATA, seq, 1'b0, '0);
        end else begin
            emit_ack(rar_pkg::K_BEYOND, seq, 1'b0, '0);
        end
    endfunction

    function automatic void predict_acks(pkt_t p);
        int   first;
        ack_t a;
        first = ack_q.size();
        if (rx_phase == RX_DONE || rx_phase == RX_FAILED) return;
        if (p.cmd == CMD_TICK) begin
            if (idle_ticks != 32'hFFFF_FFFF) idle_ticks = idle_ticks + 32'd1;
            if (idle_ticks >= timeout_lim) begin
                rx_phase = RX_FAILED;
                emit_ack(rar_pkg::K_TIMEOUT, '0, 1'b0, '0);
            end
        end else if (p.fmt_ok) begin
            if (rx_phase == RX_IDLE) begin
                if (p.mtype == rar_pkg::MT_START) begin
                    peer_conn_q = p.conn;
                    peer_addr_q = p.src;
                    idle_ticks  = '0;
                    rx_phase    = RX_OPEN;
                    emit_ack(rar_pkg::K_CSTART, p.seq, 1'b0, '0);
                end
            end else if (p.conn == peer_conn_q && p.src == peer_addr_q) begin
                if (p.mtype == rar_pkg::MT_START) begin
                    // repeated start: confirmed, but no progress
                    emit_ack(rar_pkg::K_CSTART, p.seq, 1'b0, '0);
                end else if (p.mtype == rar_pkg::MT_DATA) begin
                    take_data(p.seq, p.pay);
                end else if (p.mtype == rar_pkg::MT_END && p.seq == next_id) begin
                    idle_ticks = '0;
                    rx_phase   = RX_DONE;
                    emit_ack(rar_pkg::K_CEND, p.seq, 1'b0, '0);
                end
            end
        end
        if (ack_q.size() > first) begin
            a = ack_q[ack_q.size()-1];
            a.last = 1'b1;
            ack_q[ack_q.size()-1] = a;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errs++;
        end
    endfunction

    function automatic void check_ack();
        ack_t e;
        if (ack_q.size() == 0) begin
            $error("unexpected result: kind %0d id %0h", m_tuser[2:0], m_tdata[31:0]);
            errs++;
            return;
        end
        e = ack_q.pop_front();
        cmp_field("kind",        32'(e.kind), 32'(m_tuser[2:0]));
        cmp_field("deliver",     32'(e.dlv),  32'(m_tuser[3]));
        cmp_field("ack_id",      e.id,        m_tdata[31:0]);
        cmp_field("ack_conn",    e.conn,      m_tdata[63:32]);
        cmp_field("payload_out", e.pay,       m_tdata[95:64]);
        cmp_field("last",        32'(e.last), 32'(m_tlast));
    endfunction

    // handshakes are sampled at the rising edge, against pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) timeout_lim = cfg_wdata;
            if (m_tvalid && m_tready) begin
                m_took = 1'b1;
                check_ack();
            end
            if (s_tvalid && s_tready) begin
                s_took = 1'b1;
                predict_acks(pkt_q.pop_front());
            end
        end
    end

    // watchdog: no request moving on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIMIT) begin
            $display("[reorder_ack_receiver_unit] ERROR");
            $finish;
        end
    end

    // long hold-off of the receiver, counted here so the sender keeps going
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // sender: offers the head of pkt_q, gap drawn per request
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (s_took || !s_tvalid) begin
            s_took = 1'b0;
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pkt_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pkt_q[0].pay, pkt_q[0].src, pkt_q[0].seq, pkt_q[0].conn};
                s_tuser  <= {pkt_q[0].mtype, pkt_q[0].fmt_ok, pkt_q[0].cmd};
                if ($urandom_range(0, 19) == 0) s_burst = !s_burst;
                s_gap = s_burst ? 0 : $urandom_range(0, 13);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall drawn per result, plus the long hold-off
    always @(negedge aclk) begin
        if (m_took) begin
            m_took = 1'b0;
            if ($urandom_range(0, 19) == 0) m_burst = !m_burst;
            m_gap = m_burst ? 0 : $urandom_range(0, 13);
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap = m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    logic [31:0] peer_c;
    logic [31:0] peer_a;

    function automatic void push_pkt(logic cmd, logic fmt_ok, logic [1:0] mtype,
                                     logic [31:0] conn, logic [31:0] seq,
                                     logic [31:0] src, logic [31:0] pay);
        pkt_t p;
        p.cmd    = cmd;
        p.fmt_ok = fmt_ok;
        p.mtype  = mtype;
        p.conn   = conn;
        p.seq    = seq;
        p.src    = src;
        p.pay    = pay;
        pkt_q.push_back(p);
    endfunction

    function automatic void push_data(logic [31:0] seq, logic [31:0] pay);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA, peer_c, seq, peer_a, pay);
    endfunction

    // disturbances between well-formed data; g is the first id of the current run
    function automatic void push_noise(logic [31:0] g);
        case ($urandom_range(0, 8))
            0: push_pkt(CMD_TICK, 1'($urandom), 2'($urandom), $urandom, $urandom,
                        $urandom, $urandom);
            1: push_pkt(CMD_PKT, 1'b0, 2'($urandom), $urandom, $urandom, $urandom,
                        $urandom);
            2: push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA,
                        peer_c ^ (32'd1 << $urandom_range(0, 31)), g, peer_a, $urandom);
            3: push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA, peer_c,
                        g, peer_a ^ (32'd1 << $urandom_range(0, 31)), $urandom);
            4: push_pkt(CMD_PKT, 1'b1, MT_OTHER, peer_c, g, peer_a, $urandom);
            5: push_data($urandom, $urandom);                  // mostly beyond the window
            6: push_data($urandom_range(0, int'(g) - 1), $urandom); // older id
            7: push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_START, peer_c, $urandom, peer_a,
                        $urandom);
            default: push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_END, peer_c, g + 32'd40, peer_a,
                              $urandom);
        endcase
    endfunction

    // a run of k consecutive ids sent shuffled, descending or in order
    function automatic void push_block(inout logic [31:0] g);
        int k;
        int mode;
        int ord[WIN];
        int j;
        int t;
        k    = $urandom_range(1, WIN);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) ord[i] = (mode == 1) ? k - 1 - i : i;
        if (mode >= 2) begin
            for (int i = k - 1; i > 0; i--) begin
                j      = $urandom_range(0, i);
                t      = ord[i];
                ord[i] = ord[j];
                ord[j] = t;
            end
        end
        for (int i = 0; i < k; i++) begin
            push_data(g + 32'(ord[i]), $urandom);
            live_cnt++;
            if ($urandom_range(0, 5) == 0) begin
                push_data(g + 32'(ord[$urandom_range(0, i)]), $urandom);
                live_cnt++;
            end
            if ($urandom_range(0, 5) == 0) push_noise(g);
        end
        g = g + 32'(k);
    endfunction

    // no write while anything is in flight; ignored requests leave no trace,
    // so give the sequencer its worst-case latency on top
    task automatic wait_drained();
        while (pkt_q.size() != 0 || s_tvalid || ack_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    logic [31:0] gen_id;
    bit          end_by_timeout;

    initial begin
        peer_c = $urandom;
        peer_a = $urandom;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // waiting for start, default timeout: everything but a start is dropped
        push_pkt(CMD_TICK, 1'b0, rar_pkg::MT_START, '0, '0, '0, '0);
        push_pkt(CMD_PKT, 1'b0, rar_pkg::MT_START, peer_c, '0, peer_a, '0);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA, peer_c, '0, peer_a, 32'hFFFF_FFFF);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_END, peer_c, '0, peer_a, '0);
        push_pkt(CMD_PKT, 1'b1, MT_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_START, peer_c, 32'hFFFF_FFFF, peer_a,
                 32'hFFFF_FFFF);

        write_timeout(32'hFFFF_FFFF);

        // open transfer: repeated start, foreign peer, early end, window edges
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_START, peer_c, '0, peer_a, '0);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA, ~peer_c, '0, peer_a, 32'h1111_1111);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_DATA, peer_c, '0, ~peer_a, 32'h2222_2222);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_END, peer_c, 32'd5, peer_a, '0);
        push_data(32'hFFFF_FFFF, 32'h3333_3333);  // far beyond
        push_data(32'(WIN), 32'h4444_4444);       // first id past the window
        push_data(32'(WIN - 1), '0);              // last id inside, stored
        push_data(32'(WIN - 1), 32'h5555_5555);   // stored again, first payload kept
        push_data(32'd1, $urandom);               // stored
        push_data(32'd0, 32'hFFFF_FFFF);          // in order, releases id 1
        push_data(32'd0, $urandom);               // older, confirmed again
        push_pkt(CMD_PKT, 1'b0, rar_pkg::MT_DATA, peer_c, 32'd2, peer_a, $urandom);
        push_pkt(CMD_TICK, 1'b1, rar_pkg::MT_DATA, '0, '0, '0, '0);
        push_pkt(CMD_PKT, 1'b1, MT_OTHER, peer_c, 32'd2, peer_a, $urandom);
        gen_id = 32'd2;

        // random transfer in three timeout settings; first one under a long hold
        write_timeout(32'hFFFF_FFFF);
        hold_req = 1'b1;
        while (live_cnt < 70) push_block(gen_id);
        write_timeout($urandom_range(200, 5000));
        while (live_cnt < 135) push_block(gen_id);
        write_timeout($urandom_range(5000, 100000));
        while (live_cnt < 200) push_block(gen_id);

        // the transfer ends once per reset: either by a matching end or a timeout
        end_by_timeout = 1'($urandom_range(0, 1));
        if (end_by_timeout) begin
            write_timeout($urandom_range(1, 4));
            for (int i = 0; i < 6; i++) begin
                push_pkt(CMD_TICK, 1'b0, rar_pkg::MT_DATA, '0, '0, '0, '0);
                push_data(gen_id - 32'd1, $urandom);  // reconfirm, no progress
            end
        end else begin
            write_timeout(32'd1);
            push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_END, peer_c, gen_id, peer_a, $urandom);
            push_pkt(CMD_TICK, 1'b1, rar_pkg::MT_END, '0, '0, '0, '0);
        end
        // finished or failed: all of these are dropped
        push_data(gen_id, $urandom);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_START, peer_c, $urandom, peer_a, $urandom);
        push_pkt(CMD_PKT, 1'b1, rar_pkg::MT_END, peer_c, gen_id, peer_a, $urandom);
        push_pkt(CMD_TICK, 1'b0, rar_pkg::MT_START, '0, '0, '0, '0);

        wait_drained();
        if (errs == 0 && ack_q.size() == 0) begin
            $display("[reorder_ack_receiver_unit] OK");
        end else begin
            if (ack_q.size() != 0) $error("%0d results never arrived", ack_q.size());
            $display("[reorder_ack_receiver_unit] ERROR");
        end
        $finish;
    end

endmodule
